// ===== src/tsw_pkg.sv =====
// ----------------------------------------------------------------------------
// tsw_pkg
// Shared sizes, tables, microcode types and helper functions for the tuple
// sampler that draws without replacement.
// ----------------------------------------------------------------------------
package tsw_pkg;

	// Alphabet and tree depth.
	localparam int ALPHA      = 4;
	localparam int MAX_DEPTH  = 4;

	// Fixed field widths.
	localparam int RND_W      = 31;
	localparam int RAND_WORDS = 4;
	localparam int CFG_W      = 3;
	localparam int SYM_W      = 2;
	localparam int POS_W      = 2;

	// Integer power of the alphabet size, used at elaboration only.
	function automatic int kpow(input int e);
		int y;
		y = 1;
		for (int i = 0; i < e; i++) begin
			y = y * ALPHA;
		end
		return y;
	endfunction

	// Number of tree nodes on all levels above level d.
	function automatic int node_first(input int d);
		int s;
		s = 0;
		for (int i = 0; i < d; i++) begin
			s = s + kpow(i);
		end
		return s;
	endfunction

	// Derived sizes.
	localparam int NODE_COUNT = node_first(MAX_DEPTH);
	localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CNT_W      = $clog2(kpow(MAX_DEPTH - 1) + 1);
	localparam int TL_W       = $clog2(kpow(MAX_DEPTH) + 1);
	localparam int J_W        = $clog2(ALPHA);
	localparam int LVL_W      = $clog2(MAX_DEPTH + 1);
	localparam int SUM_W      = CNT_W + $clog2(ALPHA);
	localparam int CMP_W      = (SUM_W > TL_W) ? SUM_W : TL_W;
	localparam int ROW_W      = ALPHA * CNT_W;

	// Remainder unit: DIV_R quotient bits per cycle.
	localparam int DIV_R      = 4;
	localparam int DIV_ITERS  = (RND_W + DIV_R - 1) / DIV_R;
	localparam int DIV_W      = DIV_ITERS * DIV_R;
	localparam int IT_W       = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

	// Stream widths, padded to whole bytes.
	localparam int IN_DATA_W  = ((RAND_WORDS * RND_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((SYM_W + POS_W + 7) / 8) * 8;

	// One memory row holds the child counts of one node.
	typedef logic [ALPHA-1:0][CNT_W-1:0] row_t;

	// Tables indexed by level.
	typedef logic [MAX_DEPTH:0][TL_W-1:0]   pow_tab_t;
	typedef logic [MAX_DEPTH:0][NODE_W-1:0] last_row_tab_t;

	function automatic pow_tab_t make_pow_tab();
		pow_tab_t t;
		for (int e = 0; e <= MAX_DEPTH; e++) begin
			t[e] = TL_W'(kpow(e));
		end
		return t;
	endfunction

	function automatic last_row_tab_t make_last_row_tab();
		last_row_tab_t t;
		for (int d = 0; d <= MAX_DEPTH; d++) begin
			t[d] = NODE_W'(node_first(d + 1) - 1);
		end
		return t;
	endfunction

	// Powers of the alphabet size, and the last node index of each level.
	localparam pow_tab_t      KPOW_TAB     = make_pow_tab();
	localparam last_row_tab_t LAST_ROW_TAB = make_last_row_tab();

	// Clamp the configured tuple length into the supported depth range.
	function automatic logic [LVL_W-1:0] eff_depth(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return LVL_W'(1);
		end
		if (int'(v) > MAX_DEPTH) begin
			return LVL_W'(MAX_DEPTH);
		end
		return LVL_W'(v);
	endfunction

	// Datapath operations selected by the control word.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_FETCH,
		OP_DRAW_INIT,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SCAN_INIT,
		OP_SCAN,
		OP_UPDATE,
		OP_EMIT_SYM,
		OP_EMIT_EXH,
		OP_RF_INIT,
		OP_RF_WRITE,
		OP_EMIT_DONE
	} op_t;

	// Jump conditions.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_REFILL,
		C_EMPTY,
		C_DIV_MORE,
		C_SCAN_MORE,
		C_LVL_LAST,
		C_RF_MORE
	} cond_t;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} uword_t;

	// Datapath status seen by the sequencer.
	typedef struct packed {
		logic in_beat;
		logic out_free;
		logic refill;
		logic empty;
		logic div_more;
		logic scan_more;
		logic lvl_last;
		logic rf_more;
	} seq_stat_t;

	// Control handed to the datapath: the operation and whether it runs now.
	typedef struct packed {
		op_t  op;
		logic run;
	} seq_ctrl_t;

endpackage

// ===== src/tuple_sampler_without_replacement_top.sv =====
// ----------------------------------------------------------------------------
// tuple_sampler_without_replacement_top
// Draws every tuple over the alphabet exactly once in random order, walking a
// tree of remaining-leaf counts kept one node per memory row.
// ----------------------------------------------------------------------------
// Refill: one memory row written per cycle.
// Draw: a level is set by the remainder unit (4 bits per cycle) and the
//   one-child-per-cycle scan.
// One item is in flight at a time.
// Reset is asynchronous: no tuples left, depth 4, counts undefined until refill.
module tuple_sampler_without_replacement_top import tsw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel: tuple_length.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data,
	// Input stream.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // random_level0, 1, 2, 3
	input  logic [0:0]            s_axis_tuser,   // action
	// Output stream.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // symbol, position
	output logic                  m_axis_tlast,
	output logic [1:0]            m_axis_tuser    // exhausted, refill_done
);

	seq_stat_t stat;
	seq_ctrl_t ctrl;

	// Configuration and long-lived state.
	logic [CFG_W-1:0] tuple_length_q;
	logic [LVL_W-1:0] depth_q;
	logic [TL_W-1:0]  tuples_left_q;

	// Item and walk registers.
	logic                            action_q;
	logic [RAND_WORDS-1:0][RND_W-1:0] rand_q;
	logic [LVL_W-1:0]                level_q;
	logic [NODE_W-1:0]               node_q;
	logic [TL_W-1:0]                 lvlcount_q;
	logic [TL_W-1:0]                 rem_q;
	logic [DIV_W-1:0]                dvd_q;
	logic [IT_W-1:0]                 iter_q;
	row_t                            row_q;
	logic [J_W-1:0]                  j_q;
	logic [J_W-1:0]                  pick_q;
	logic [CNT_W-1:0]                pcnt_q;
	logic [SUM_W-1:0]                sum_q;

	// Output register.
	logic             out_valid_q;
	logic [SYM_W-1:0] out_sym_q;
	logic [POS_W-1:0] out_pos_q;
	logic             out_last_q;
	logic             out_exh_q;
	logic             out_done_q;

	// Combinational datapath signals.
	logic             in_beat;
	logic             out_free;
	logic             run;
	logic [1:0]       rsel;
	logic [TL_W:0]    div_r;
	logic [TL_W-1:0]  div_rem;
	logic [SUM_W-1:0] sum_nx;
	logic             hit;
	logic [CNT_W-1:0] dec_cnt;
	logic [CNT_W-1:0] rf_val;
	logic             lvl_last;
	logic             mem_wr_en;
	row_t             mem_wr_data;
	row_t             mem_rd_data;

	// Handshakes.
	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (ctrl.op == OP_FETCH);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign run           = ctrl.run;

	// Random word for the current level, taken modulo the number of words.
	assign rsel = 2'(level_q);

	// Remainder unit: DIV_R restoring steps per cycle, dividend MSB first.
	always_comb begin
		div_rem = rem_q;
		div_r   = '0;
		for (int b = 0; b < DIV_R; b++) begin
			div_r = {div_rem, dvd_q[DIV_W-1-b]};
			if (div_r >= {1'b0, lvlcount_q}) begin
				div_r = div_r - {1'b0, lvlcount_q};
			end
			div_rem = div_r[TL_W-1:0];
		end
	end

	// Running prefix sum over the children of the current node.
	assign sum_nx  = sum_q + SUM_W'(row_q[j_q]);
	assign hit     = CMP_W'(sum_nx) > CMP_W'(rem_q);
	assign dec_cnt = (pcnt_q != '0) ? CNT_W'(pcnt_q - 1'b1) : '0;

	assign lvl_last = (LVL_W'(level_q + 1'b1) == depth_q);
	assign rf_val   = CNT_W'(KPOW_TAB[LVL_W'(depth_q - 1'b1 - level_q)]);

	// Memory write data: a decremented row or a refill row.
	always_comb begin
		for (int i = 0; i < ALPHA; i++) begin
			if (ctrl.op == OP_RF_WRITE) begin
				mem_wr_data[i] = rf_val;
			end else if (J_W'(i) == pick_q) begin
				mem_wr_data[i] = dec_cnt;
			end else begin
				mem_wr_data[i] = row_q[i];
			end
		end
	end

	assign mem_wr_en = run && ((ctrl.op == OP_UPDATE) || (ctrl.op == OP_RF_WRITE));

	// Status for the sequencer.
	assign stat.in_beat   = in_beat;
	assign stat.out_free  = out_free;
	assign stat.refill    = !action_q;
	assign stat.empty     = (tuples_left_q == '0);
	assign stat.div_more  = (iter_q != IT_W'(DIV_ITERS - 1));
	assign stat.scan_more = !hit && (j_q != J_W'(ALPHA - 1));
	assign stat.lvl_last  = lvl_last;
	assign stat.rf_more   = (node_q != LAST_ROW_TAB[LVL_W'(depth_q - 1'b1)]);

	tsw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// Child counts, one node per row.
	tsw_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NODE_COUNT)
	) u_counts (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (node_q),
		.wr_data (mem_wr_data),
		.rd_addr (node_q),
		.rd_data (mem_rd_data)
	);

	// Control state: configuration, depth, tuple count, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuple_length_q <= CFG_W'(4);
			depth_q        <= eff_depth(CFG_W'(4));
			tuples_left_q  <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tuple_length_q <= cfg_data;
			end
			if (run && (ctrl.op == OP_RF_INIT)) begin
				depth_q       <= eff_depth(tuple_length_q);
				tuples_left_q <= KPOW_TAB[eff_depth(tuple_length_q)];
			end
			if (run && (ctrl.op == OP_DRAW_INIT)) begin
				tuples_left_q <= tuples_left_q - 1'b1;
			end
			if (run && ((ctrl.op == OP_EMIT_SYM) || (ctrl.op == OP_EMIT_EXH) ||
					(ctrl.op == OP_EMIT_DONE))) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, driven by the current control word.
	always_ff @(posedge clk) begin
		if (run) begin
			case (ctrl.op)
				OP_FETCH: begin
					action_q <= s_axis_tuser[0];
					rand_q   <= s_axis_tdata[RAND_WORDS*RND_W-1:0];
				end
				OP_DRAW_INIT: begin
					lvlcount_q <= tuples_left_q;
					node_q     <= '0;
					level_q    <= '0;
				end
				OP_DIV_INIT: begin
					dvd_q  <= DIV_W'(rand_q[rsel]);
					rem_q  <= '0;
					iter_q <= '0;
				end
				OP_DIV_STEP: begin
					rem_q  <= div_rem;
					dvd_q  <= dvd_q << DIV_R;
					iter_q <= IT_W'(iter_q + 1'b1);
				end
				OP_SCAN_INIT: begin
					row_q  <= mem_rd_data;
					j_q    <= '0;
					sum_q  <= '0;
					pick_q <= J_W'(ALPHA - 1);
					pcnt_q <= mem_rd_data[ALPHA-1];
					if (lvlcount_q == '0) begin
						rem_q <= '0;
					end
				end
				OP_SCAN: begin
					sum_q <= sum_nx;
					j_q   <= J_W'(j_q + 1'b1);
					if (hit) begin
						pick_q <= j_q;
						pcnt_q <= row_q[j_q];
					end
				end
				OP_UPDATE: begin
					lvlcount_q <= TL_W'(pcnt_q);
				end
				OP_EMIT_SYM: begin
					out_sym_q  <= SYM_W'(pick_q);
					out_pos_q  <= POS_W'(level_q);
					out_last_q <= lvl_last;
					out_exh_q  <= 1'b0;
					out_done_q <= 1'b0;
					node_q     <= NODE_W'(int'(node_q) * ALPHA + 1 + int'(pick_q));
					level_q    <= LVL_W'(level_q + 1'b1);
				end
				OP_EMIT_EXH: begin
					out_sym_q  <= '0;
					out_pos_q  <= '0;
					out_last_q <= 1'b1;
					out_exh_q  <= 1'b1;
					out_done_q <= 1'b0;
				end
				OP_RF_INIT: begin
					node_q  <= '0;
					level_q <= '0;
				end
				OP_RF_WRITE: begin
					node_q <= NODE_W'(node_q + 1'b1);
					if (node_q == LAST_ROW_TAB[level_q]) begin
						level_q <= LVL_W'(level_q + 1'b1);
					end
				end
				OP_EMIT_DONE: begin
					out_sym_q  <= '0;
					out_pos_q  <= '0;
					out_last_q <= 1'b1;
					out_exh_q  <= 1'b0;
					out_done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Output stream.
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_pos_q, out_sym_q});
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = {out_done_q, out_exh_q};

endmodule

// ===== src/tsw_ram.sv =====
// ----------------------------------------------------------------------------
// tsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ===== src/tsw_seq.sv =====
// ----------------------------------------------------------------------------
// tsw_seq
// Microcode sequencer: a step counter walks a read-only program, one control
// word per step, with conditional jumps and stalls on the stream handshakes.
// ----------------------------------------------------------------------------
module tsw_seq import tsw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  seq_stat_t stat,
	output seq_ctrl_t ctrl
);

	// Program labels.
	localparam pc_t PC_FETCH    = 4'd0;
	localparam pc_t PC_DISPATCH = 4'd1;
	localparam pc_t PC_CHECK    = 4'd2;
	localparam pc_t PC_DRAW     = 4'd3;
	localparam pc_t PC_LEVEL    = 4'd4;
	localparam pc_t PC_DIV      = 4'd5;
	localparam pc_t PC_SCAN0    = 4'd6;
	localparam pc_t PC_SCAN     = 4'd7;
	localparam pc_t PC_UPDATE   = 4'd8;
	localparam pc_t PC_EMIT     = 4'd9;
	localparam pc_t PC_NEXT     = 4'd10;
	localparam pc_t PC_EXH      = 4'd11;
	localparam pc_t PC_RF0      = 4'd12;
	localparam pc_t PC_RF       = 4'd13;
	localparam pc_t PC_DONE     = 4'd14;

	// The control program.
	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		w = '{op: OP_NONE, cond: C_ALWAYS, target: PC_FETCH};
		case (pc)
			PC_FETCH:    w = '{op: OP_FETCH,     cond: C_NEVER,     target: PC_FETCH};
			PC_DISPATCH: w = '{op: OP_NONE,      cond: C_REFILL,    target: PC_RF0};
			PC_CHECK:    w = '{op: OP_NONE,      cond: C_EMPTY,     target: PC_EXH};
			PC_DRAW:     w = '{op: OP_DRAW_INIT, cond: C_NEVER,     target: PC_FETCH};
			PC_LEVEL:    w = '{op: OP_DIV_INIT,  cond: C_NEVER,     target: PC_FETCH};
			PC_DIV:      w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE,  target: PC_DIV};
			PC_SCAN0:    w = '{op: OP_SCAN_INIT, cond: C_NEVER,     target: PC_FETCH};
			PC_SCAN:     w = '{op: OP_SCAN,      cond: C_SCAN_MORE, target: PC_SCAN};
			PC_UPDATE:   w = '{op: OP_UPDATE,    cond: C_NEVER,     target: PC_FETCH};
			PC_EMIT:     w = '{op: OP_EMIT_SYM,  cond: C_LVL_LAST,  target: PC_FETCH};
			PC_NEXT:     w = '{op: OP_NONE,      cond: C_ALWAYS,    target: PC_LEVEL};
			PC_EXH:      w = '{op: OP_EMIT_EXH,  cond: C_ALWAYS,    target: PC_FETCH};
			PC_RF0:      w = '{op: OP_RF_INIT,   cond: C_NEVER,     target: PC_FETCH};
			PC_RF:       w = '{op: OP_RF_WRITE,  cond: C_RF_MORE,   target: PC_RF};
			PC_DONE:     w = '{op: OP_EMIT_DONE, cond: C_ALWAYS,    target: PC_FETCH};
			default:     w = '{op: OP_NONE,      cond: C_ALWAYS,    target: PC_FETCH};
		endcase
		return w;
	endfunction

	pc_t    pc_q;
	uword_t uw;
	logic   hold;
	logic   take;

	assign uw = ucode(pc_q);

	// Stall on a missing input beat or a full output register.
	always_comb begin
		case (uw.op)
			OP_FETCH:                              hold = !stat.in_beat;
			OP_EMIT_SYM, OP_EMIT_EXH, OP_EMIT_DONE: hold = !stat.out_free;
			default:                               hold = 1'b0;
		endcase
	end

	// Jump condition select.
	always_comb begin
		case (uw.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_REFILL:    take = stat.refill;
			C_EMPTY:     take = stat.empty;
			C_DIV_MORE:  take = stat.div_more;
			C_SCAN_MORE: take = stat.scan_more;
			C_LVL_LAST:  take = stat.lvl_last;
			C_RF_MORE:   take = stat.rf_more;
			default:     take = 1'b0;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_FETCH;
		end else if (!hold) begin
			pc_q <= take ? uw.target : pc_t'(pc_q + 1'b1);
		end
	end

	assign ctrl.op  = uw.op;
	assign ctrl.run = !hold;

endmodule

// ===== src/tsw_checker.sv =====
// ----------------------------------------------------------------------------
// tsw_checker
// Port-level checks on the tuple sampler, bound to the top level.
// ----------------------------------------------------------------------------
module tsw_checker import tsw_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast,
	input logic [1:0]            m_axis_tuser
);

	// A stalled result beat holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
			$stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// A result is never both exhausted and a refill answer.
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("exhausted and refill_done both set");

	// Flagged results are single, last and carry symbol 0 at position 0.
	a_flag_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != 2'b00) |-> m_axis_tlast && (m_axis_tdata == '0))
		else $error("flagged result is not a lone zero beat");

	// One item at a time: ready drops right after an input beat.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in progress");

endmodule

bind tuple_sampler_without_replacement_top tsw_checker u_tsw_checker (.*);
